FILE: design/assert_macros.svh
// Assertion macros shared by the frame parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, suspended while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: design/adsfp_pkg.sv
// Shared types and constants of the ASCII dual sample frame parser.
package adsfp_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 31;
    localparam int CHAN_W   = 2;
    localparam int STATUS_W = 2;
    localparam int DIGIT_W  = 4;
    localparam int CFG_IDX_W = 2;

    // Saturation limit of a parsed field
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    // ASCII digit range
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

    // Register reset values
    localparam logic [BYTE_W-1:0] HEADER_RST = 8'h23;
    localparam logic [BYTE_W-1:0] TAIL_RST   = 8'h0A;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 2'd1;

    // Result channel tags
    localparam logic [CHAN_W-1:0] CH_ECG = 2'd0;
    localparam logic [CHAN_W-1:0] CH_PPG = 2'd1;
    localparam logic [CHAN_W-1:0] CH_END = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVF   = 2'd2;

    // Commands to the field accumulator
    typedef struct packed {
        logic               clear;
        logic               add;
        logic [DIGIT_W-1:0] digit;
    } t_acc_ctl;

    // Current field state from the accumulator
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               seen;
        logic               ovf;
    } t_field;

endpackage

FILE: design/adsfp_field_acc.sv
// Decimal field accumulator with saturation at the value limit.
`include "assert_macros.svh"

module adsfp_field_acc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  adsfp_pkg::t_acc_ctl  i_ctl,
    output adsfp_pkg::t_field    o_field
);
    import adsfp_pkg::*;

    localparam int PROD_W = VALUE_W + 4;

    logic [VALUE_W-1:0] r_acc, n_acc;
    logic               r_seen, n_seen;
    logic               r_ovf, n_ovf;
    logic [PROD_W-1:0]  w_wide;
    logic [PROD_W-1:0]  w_prod;
    logic               w_big;

    // acc * 10 + digit, as two shifts and adds
    assign w_wide = {{(PROD_W-VALUE_W){1'b0}}, r_acc};
    assign w_prod = (w_wide << 3) + (w_wide << 1) + PROD_W'(i_ctl.digit);
    assign w_big  = |w_prod[PROD_W-1:VALUE_W];

    // Next field state
    always_comb begin
        n_acc  = r_acc;
        n_seen = r_seen;
        n_ovf  = r_ovf;
        if (i_ctl.clear) begin
            n_acc  = '0;
            n_seen = 1'b0;
            n_ovf  = 1'b0;
        end else if (i_ctl.add) begin
            n_seen = 1'b1;
            if (w_big) begin
                n_acc = VALUE_MAX;
                n_ovf = 1'b1;
            end else begin
                n_acc = w_prod[VALUE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_seen <= 1'b0;
            r_ovf  <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_seen <= n_seen;
            r_ovf  <= n_ovf;
        end
    end

    assign o_field.value = r_acc;
    assign o_field.seen  = r_seen;
    assign o_field.ovf   = r_ovf;

    // Saturated fields sit at the limit, and only after a digit
    `ASSERT_CLK(a_ovf_at_max, !r_ovf || (r_acc == VALUE_MAX && r_seen), "overflow without saturated value")
    `ASSERT_CLK(a_clear_empties, i_ctl.clear |=> (r_acc == '0 && !r_seen && !r_ovf), "clear left field state")
    `ASSERT_CLK(a_add_marks, (i_ctl.add && !i_ctl.clear) |=> r_seen, "digit add did not mark field")

endmodule

FILE: design/ascii_dual_sample_frame_parser.sv
// Top level of the ASCII dual sample frame parser.
//
//  channel | valid / ready           | payload
//  --------+-------------------------+---------------------------------------
//  input   | i_in_valid / o_in_ready | i_rx_byte
//  result  | o_out_valid/i_out_ready | o_channel, o_sample_value, o_status
//  config  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each byte is captured in the input register, is parsed by the phase
// logic and the x10 accumulator, and its result (if any) lands in the result
// register; one byte per cycle is sustained while the result register is not
// stalled.
// A stalled result register holds the byte in the input register; the input
// takes a new byte in the same cycle that the held one moves on.
// Synchronous reset restores the header and tail bytes and waits for a header.
`include "assert_macros.svh"

module ascii_dual_sample_frame_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Byte input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [adsfp_pkg::BYTE_W-1:0]      i_rx_byte,
    // Results
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [adsfp_pkg::CHAN_W-1:0]      o_channel,
    output logic [adsfp_pkg::VALUE_W-1:0]     o_sample_value,
    output logic [adsfp_pkg::STATUS_W-1:0]    o_status,
    // Configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [adsfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [adsfp_pkg::BYTE_W-1:0]      i_cfg_data
);
    import adsfp_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_ECG,
        PH_PPG,
        PH_TAIL
    } t_phase;

    t_phase              r_phase, n_phase;
    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic                r_out_valid;
    logic [CHAN_W-1:0]   r_chan, n_chan;
    logic [VALUE_W-1:0]  r_val, n_val;
    logic [STATUS_W-1:0] r_stat, n_stat;
    logic [BYTE_W-1:0]   r_header, r_tail;

    logic                w_advance;
    logic                w_is_digit;
    logic                w_emit;
    t_acc_ctl            w_ctl;
    t_field              w_field;
    logic [VALUE_W-1:0]  w_fval;
    logic [STATUS_W-1:0] w_fstat;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RST;
            r_tail   <= TAIL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_HEADER: r_header <= i_cfg_data;
                REG_TAIL:   r_tail   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Held byte moves on when the result register is free or being drained
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    assign w_is_digit = (r_in_byte >= ASCII_ZERO) && (r_in_byte <= ASCII_NINE);

    // Field result: empty, saturated or plain
    always_comb begin
        if (!w_field.seen) begin
            w_fval  = '0;
            w_fstat = ST_EMPTY;
        end else begin
            w_fval  = w_field.value;
            w_fstat = w_field.ovf ? ST_OVF : ST_OK;
        end
    end

    // Phase decode for the held byte
    always_comb begin
        n_phase     = r_phase;
        w_emit      = 1'b0;
        n_chan      = CH_END;
        n_val       = '0;
        n_stat      = ST_OK;
        w_ctl.clear = 1'b0;
        w_ctl.add   = 1'b0;
        w_ctl.digit = r_in_byte[DIGIT_W-1:0];
        unique case (r_phase) inside
            PH_HEADER: begin
                if (r_in_byte == r_header) begin
                    w_ctl.clear = 1'b1;
                    n_phase     = PH_ECG;
                end
            end
            PH_ECG, PH_PPG: begin
                if (w_is_digit) begin
                    w_ctl.add = 1'b1;
                end else begin
                    w_emit      = 1'b1;
                    w_ctl.clear = 1'b1;
                    n_chan      = (r_phase == PH_ECG) ? CH_ECG : CH_PPG;
                    n_val       = w_fval;
                    n_stat      = w_fstat;
                    n_phase     = (r_phase == PH_ECG) ? PH_PPG : PH_TAIL;
                end
            end
            PH_TAIL: begin
                if (r_in_byte == r_tail) begin
                    w_emit  = 1'b1;
                    n_phase = PH_HEADER;
                end
            end
            default: ;
        endcase
        if (!w_advance) begin
            w_ctl.clear = 1'b0;
            w_ctl.add   = 1'b0;
        end
    end

    adsfp_field_acc u_field (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_field (w_field)
    );

    // Phase, input register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
                r_in_byte  <= i_rx_byte;
            end
            if (w_advance) begin
                r_phase <= n_phase;
            end
            if (w_advance && w_emit) begin
                r_out_valid <= 1'b1;
                r_chan      <= n_chan;
                r_val       <= n_val;
                r_stat      <= n_stat;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_channel      = r_chan;
    assign o_sample_value = r_val;
    assign o_status       = r_stat;

    `ASSERT_CLK(a_ecg_end, (w_advance && r_phase == PH_ECG && !w_is_digit) |=> (r_phase == PH_PPG && r_out_valid && r_chan == CH_ECG), "ECG field end not issued")
    `ASSERT_CLK(a_end_clean, (r_out_valid && r_chan == CH_END) |-> (r_val == '0 && r_stat == ST_OK), "frame end carries data")
    `ASSERT_CLK(a_stall_holds, !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready), "input blocked without a stalled result")

endmodule
